FILE: src/vtfb_pkg.sv
// shared types, constants and helpers of the vertex tangent frame builder
`timescale 1ns / 1ps

package vtfb_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TRI     = 2'd1;
    localparam logic [1:0] ACT_RESOLVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } vrec_t;

    typedef struct packed {
        logic signed [47:0] tan_x;
        logic signed [47:0] tan_y;
        logic signed [47:0] tan_z;
        logic signed [47:0] bit_x;
        logic signed [47:0] bit_y;
        logic signed [47:0] bit_z;
    } acc_rec_t;

    function automatic logic [47:0] mag48(input logic signed [47:0] x);
        logic signed [47:0] n;
        n = -x;
        return x[47] ? 48'(n) : 48'(x);
    endfunction

    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47])
            return s[48] ? ACC_MIN : ACC_MAX;
        return s[47:0];
    endfunction

endpackage

FILE: src/vertex_tangent_frame_builder_unit.sv
// vertex tangent frame builder: vertex store, accumulators and arithmetic sequencer
`timescale 1ns / 1ps
// work: a clear zeroes all 1024 accumulator entries; a triangle runs six divisions with
//   56-bit quotients on one restoring divider; a resolve runs alignment shifts, a square
//   root giving 32 result bits and three such divisions; one item at a time
// a finished resolve result waits in the output register while the next item is taken
// reset: control registers cleared, then a clearing pass zeroes the 1024-entry accumulator
//   memory before the first input transfer is taken; configuration writes are always taken
module vertex_tangent_frame_builder_unit
    import vtfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // index_a, index_b, index_c, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
    input  logic [183:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_index, tan_x, tan_y, tan_z
    output logic [63:0]  m_tdata,
    // handedness_negative
    output logic         m_tuser
);

    // sequencer states
    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_CLR    = 6'd1;
    localparam logic [5:0] ST_T_RDA  = 6'd2;
    localparam logic [5:0] ST_T_RDB  = 6'd3;
    localparam logic [5:0] ST_T_RDC  = 6'd4;
    localparam logic [5:0] ST_T_EDGE = 6'd5;
    localparam logic [5:0] ST_T_DET0 = 6'd6;
    localparam logic [5:0] ST_T_DET1 = 6'd7;
    localparam logic [5:0] ST_T_DET2 = 6'd8;
    localparam logic [5:0] ST_T_NUM0 = 6'd9;
    localparam logic [5:0] ST_T_NUM1 = 6'd10;
    localparam logic [5:0] ST_T_NUM2 = 6'd11;
    localparam logic [5:0] ST_T_DIV  = 6'd12;
    localparam logic [5:0] ST_T_DIVF = 6'd13;
    localparam logic [5:0] ST_T_ARD  = 6'd14;
    localparam logic [5:0] ST_T_AWR  = 6'd15;
    localparam logic [5:0] ST_R_RD   = 6'd16;
    localparam logic [5:0] ST_R_CAP  = 6'd17;
    localparam logic [5:0] ST_ALIGN  = 6'd18;
    localparam logic [5:0] ST_R_NDT  = 6'd19;
    localparam logic [5:0] ST_R_NDTS = 6'd20;
    localparam logic [5:0] ST_R_PLO  = 6'd21;
    localparam logic [5:0] ST_R_PHI  = 6'd22;
    localparam logic [5:0] ST_R_OSUB = 6'd23;
    localparam logic [5:0] ST_R_OLD  = 6'd24;
    localparam logic [5:0] ST_R_LEN  = 6'd25;
    localparam logic [5:0] ST_R_SQI  = 6'd26;
    localparam logic [5:0] ST_R_SQRT = 6'd27;
    localparam logic [5:0] ST_R_SQF  = 6'd28;
    localparam logic [5:0] ST_R_NDS  = 6'd29;
    localparam logic [5:0] ST_R_NDIV = 6'd30;
    localparam logic [5:0] ST_R_NDF  = 6'd31;
    localparam logic [5:0] ST_R_CRA  = 6'd32;
    localparam logic [5:0] ST_R_CRB  = 6'd33;
    localparam logic [5:0] ST_R_CRS  = 6'd34;
    localparam logic [5:0] ST_R_DOT  = 6'd35;
    localparam logic [5:0] ST_R_HD   = 6'd36;
    localparam logic [5:0] ST_R_OUT  = 6'd37;

    // what the shared alignment step is working on
    localparam logic [1:0] PH_T = 2'd0;   // accumulated tangent
    localparam logic [1:0] PH_O = 2'd1;   // orthogonalized tangent
    localparam logic [1:0] PH_F = 2'd2;   // fallback axis cross product
    localparam logic [1:0] PH_B = 2'd3;   // accumulated bitangent

    // multiply-accumulate operations
    localparam logic [2:0] MAC_HOLD  = 3'd0;
    localparam logic [2:0] MAC_LOAD  = 3'd1;
    localparam logic [2:0] MAC_ADD   = 3'd2;
    localparam logic [2:0] MAC_SUB   = 3'd3;
    localparam logic [2:0] MAC_ADDSH = 3'd4;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_VERTICES - 1);
    localparam logic [5:0]       DIV_LAST  = 6'd55;
    localparam logic [5:0]       SQRT_LAST = 6'd31;

    // input field split
    logic [1:0]         in_action;
    logic [9:0]         in_ia, in_ib, in_ic;
    vrec_t              in_rec;
    logic               s_accept;

    assign in_action     = s_tuser;
    assign in_ia         = s_tdata[9:0];
    assign in_ib         = s_tdata[19:10];
    assign in_ic         = s_tdata[29:20];
    assign in_rec.pos_x  = s_tdata[53:30];
    assign in_rec.pos_y  = s_tdata[77:54];
    assign in_rec.pos_z  = s_tdata[101:78];
    assign in_rec.tex_u  = s_tdata[117:102];
    assign in_rec.tex_v  = s_tdata[133:118];
    assign in_rec.norm_x = s_tdata[149:134];
    assign in_rec.norm_y = s_tdata[165:150];
    assign in_rec.norm_z = s_tdata[181:166];

    // configuration registers
    logic [10:0] vcount_reg;
    logic [15:0] thr_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, thr_reg} : {21'd0, vcount_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            thr_reg    <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                thr_reg <= pwdata[15:0];
            else
                vcount_reg <= pwdata[10:0];
        end
    end

    // vertex store and accumulator memories, one port each, registered read
    vrec_t      vmem [MAX_VERTICES];
    acc_rec_t   amem [MAX_VERTICES];
    logic [IDX_W-1:0] vaddr, aaddr;
    logic       vwe, awe;
    acc_rec_t   awdata;
    vrec_t      vrd_reg;
    acc_rec_t   ard_reg;

    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[vaddr] <= in_rec;
        vrd_reg <= vmem[vaddr];
        if (awe)
            amem[aaddr] <= awdata;
        ard_reg <= amem[aaddr];
    end

    // control and working registers
    logic [5:0]        state_reg, state_next;
    logic [2:0]        comp_reg, comp_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [1:0]        phase_reg, phase_next;
    logic              o_valid_reg, o_valid_next;

    logic [9:0]        ia_reg, ia_next, ib_reg, ib_next, ic_reg, ic_next;
    vrec_t             va_reg, va_next, vb_reg, vb_next;
    logic signed [24:0] e1_reg [3], e1_next [3], e2_reg [3], e2_next [3];
    logic signed [16:0] du1_reg, du1_next, dv1_reg, dv1_next;
    logic signed [16:0] du2_reg, du2_next, dv2_reg, dv2_next;
    logic signed [34:0] det_reg, det_next;
    logic              tneg_reg, tneg_next;
    logic signed [47:0] tb_reg [6], tb_next [6];

    logic signed [69:0] macc_reg, macc_next;
    logic [35:0]       div_rem_reg, div_rem_next;
    logic [55:0]       div_quo_reg, div_quo_next;
    logic [34:0]       div_den_reg, div_den_next;

    logic signed [15:0] n_reg [3], n_next [3];
    logic [47:0]       vm_reg [3], vm_next [3];
    logic              vs_reg [3], vs_next [3];
    logic signed [47:0] bt_reg [3], bt_next [3];
    logic signed [47:0] ndt_reg, ndt_next;
    logic signed [35:0] ow_reg [3], ow_next [3];
    logic [31:0]       len_reg, len_next;
    logic [63:0]       sx_reg, sx_next, sr_reg, sr_next, sbit_reg, sbit_next;
    logic signed [15:0] res_reg [3], res_next [3];
    logic signed [32:0] cr_reg [3], cr_next [3];
    logic              hd_reg, hd_next;

    logic [9:0]        o_idx_reg, o_idx_next;
    logic signed [15:0] o_tan_reg [3], o_tan_next [3];
    logic              o_hd_reg, o_hd_next;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [2:0]         macc_op;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (macc_op)
            MAC_LOAD:  macc_next = 70'(mul_p);
            MAC_ADD:   macc_next = macc_reg + 70'(mul_p);
            MAC_SUB:   macc_next = macc_reg - 70'(mul_p);
            MAC_ADDSH: macc_next = macc_reg + (70'(mul_p) <<< 24);
            default:   macc_next = macc_reg;
        endcase
    end

    // restoring divider step, one quotient bit a cycle
    logic [35:0] div_sh;
    logic [36:0] div_diff;

    assign div_sh   = {div_rem_reg[34:0], div_quo_reg[55]};
    assign div_diff = {1'b0, div_sh} - {2'b0, div_den_reg};

    // square root step, one result bit a cycle
    logic [63:0] sq_trial;
    assign sq_trial = sr_reg + sbit_reg;

    // helpers
    logic [69:0]        macc_mag;
    logic [47:0]        vmax;
    logic signed [33:0] tsv [3];
    logic [1:0]         ax;
    logic [1:0]         cj, ck;
    logic [16:0]        nmag [3];
    logic [34:0]        det_now_mag, det_reg_mag;
    logic [33:0]        rnd;
    logic signed [35:0] rnd_s;
    logic [15:0]        qclamp;

    always_comb
    begin
        macc_mag = macc_reg[69] ? 70'(-macc_reg) : 70'(macc_reg);
        vmax = vm_reg[0];
        if (vm_reg[1] > vmax)
            vmax = vm_reg[1];
        if (vm_reg[2] > vmax)
            vmax = vm_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            tsv[i]  = vs_reg[i] ? -$signed({4'd0, vm_reg[i][29:0]})
                                : $signed({4'd0, vm_reg[i][29:0]});
            nmag[i] = n_reg[i][15] ? 17'(-17'(n_reg[i])) : 17'(n_reg[i]);
        end
        ax = (comp_reg >= 3'd3) ? 2'(comp_reg - 3'd3) : comp_reg[1:0];
        case (comp_reg)
            3'd0:    begin cj = 2'd1; ck = 2'd2; end
            3'd1:    begin cj = 2'd2; ck = 2'd0; end
            default: begin cj = 2'd0; ck = 2'd1; end
        endcase
        det_now_mag = macc_reg[34] ? 35'(-macc_reg[34:0]) : macc_reg[34:0];
        det_reg_mag = det_reg[34] ? 35'(-det_reg) : 35'(det_reg);
        // round half away from zero of the magnitude over 2^28
        rnd   = 34'((macc_mag + 70'd134217728) >> 28);
        rnd_s = macc_reg[69] ? -$signed({2'b0, rnd}) : $signed({2'b0, rnd});
        qclamp = (div_quo_reg > 56'd16384) ? 16'd16384 : div_quo_reg[15:0];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        comp_next    = comp_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        phase_next   = phase_reg;
        o_valid_next = o_valid_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        ic_next      = ic_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        du1_next     = du1_reg;
        dv1_next     = dv1_reg;
        du2_next     = du2_reg;
        dv2_next     = dv2_reg;
        det_next     = det_reg;
        tneg_next    = tneg_reg;
        tb_next      = tb_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        n_next       = n_reg;
        vm_next      = vm_reg;
        vs_next      = vs_reg;
        bt_next      = bt_reg;
        ndt_next     = ndt_reg;
        ow_next      = ow_reg;
        len_next     = len_reg;
        sx_next      = sx_reg;
        sr_next      = sr_reg;
        sbit_next    = sbit_reg;
        res_next     = res_reg;
        cr_next      = cr_reg;
        hd_next      = hd_reg;
        o_idx_next   = o_idx_reg;
        o_tan_next   = o_tan_reg;
        o_hd_next    = o_hd_reg;
        mul_a        = '0;
        mul_b        = '0;
        macc_op      = MAC_HOLD;
        vwe          = 1'b0;
        awe          = 1'b0;
        awdata       = '0;

        // result register drains independently of the sequencer
        if (m_tready)
            o_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    ia_next = in_ia;
                    ib_next = in_ib;
                    ic_next = in_ic;
                    case (in_action)
                        ACT_LOAD:
                            vwe = (32'(in_ia) < MAX_VERTICES);
                        ACT_TRI:
                            if ({1'b0, in_ia} < vcount_reg && {1'b0, in_ib} < vcount_reg &&
                                {1'b0, in_ic} < vcount_reg && 32'(in_ia) < MAX_VERTICES &&
                                32'(in_ib) < MAX_VERTICES && 32'(in_ic) < MAX_VERTICES)
                                state_next = ST_T_RDA;
                        ACT_RESOLVE:
                            if ({1'b0, in_ia} < vcount_reg && 32'(in_ia) < MAX_VERTICES)
                                state_next = ST_R_RD;
                        default:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                    endcase
                end
            end

            ST_CLR:
            begin
                awe = 1'b1;
                if (clr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            // triangle: fetch corners
            ST_T_RDA: state_next = ST_T_RDB;
            ST_T_RDB:
            begin
                va_next    = vrd_reg;
                state_next = ST_T_RDC;
            end
            ST_T_RDC:
            begin
                vb_next    = vrd_reg;
                state_next = ST_T_EDGE;
            end
            ST_T_EDGE:
            begin
                e1_next[0] = 25'(vb_reg.pos_x) - 25'(va_reg.pos_x);
                e1_next[1] = 25'(vb_reg.pos_y) - 25'(va_reg.pos_y);
                e1_next[2] = 25'(vb_reg.pos_z) - 25'(va_reg.pos_z);
                e2_next[0] = 25'(vrd_reg.pos_x) - 25'(va_reg.pos_x);
                e2_next[1] = 25'(vrd_reg.pos_y) - 25'(va_reg.pos_y);
                e2_next[2] = 25'(vrd_reg.pos_z) - 25'(va_reg.pos_z);
                du1_next   = 17'(vb_reg.tex_u) - 17'(va_reg.tex_u);
                dv1_next   = 17'(vb_reg.tex_v) - 17'(va_reg.tex_v);
                du2_next   = 17'(vrd_reg.tex_u) - 17'(va_reg.tex_u);
                dv2_next   = 17'(vrd_reg.tex_v) - 17'(va_reg.tex_v);
                state_next = ST_T_DET0;
            end
            ST_T_DET0:
            begin
                mul_a      = 34'(du1_reg);
                mul_b      = 34'(dv2_reg);
                macc_op    = MAC_LOAD;
                state_next = ST_T_DET1;
            end
            ST_T_DET1:
            begin
                mul_a      = 34'(du2_reg);
                mul_b      = 34'(dv1_reg);
                macc_op    = MAC_SUB;
                state_next = ST_T_DET2;
            end
            ST_T_DET2:
            begin
                det_next  = macc_reg[34:0];
                comp_next = '0;
                // small or zero determinant drops the triangle
                if (det_now_mag <= {19'd0, thr_reg})
                    state_next = ST_IDLE;
                else
                    state_next = ST_T_NUM0;
            end
            // numerator of term comp: tangent axes first, then bitangent axes
            ST_T_NUM0:
            begin
                mul_a      = (comp_reg < 3'd3) ? 34'(e1_reg[ax]) : 34'(e2_reg[ax]);
                mul_b      = (comp_reg < 3'd3) ? 34'(dv2_reg) : 34'(du1_reg);
                macc_op    = MAC_LOAD;
                state_next = ST_T_NUM1;
            end
            ST_T_NUM1:
            begin
                mul_a      = (comp_reg < 3'd3) ? 34'(e2_reg[ax]) : 34'(e1_reg[ax]);
                mul_b      = (comp_reg < 3'd3) ? 34'(dv1_reg) : 34'(du2_reg);
                macc_op    = MAC_SUB;
                state_next = ST_T_NUM2;
            end
            ST_T_NUM2:
            begin
                div_quo_next = {1'b0, macc_mag[42:0], 12'd0};
                div_rem_next = '0;
                div_den_next = det_reg_mag;
                tneg_next    = macc_reg[69] ^ det_reg[34];
                cnt_next     = '0;
                state_next   = ST_T_DIV;
            end
            ST_T_DIV:
            begin
                if (!div_diff[36])
                begin
                    div_rem_next = div_diff[35:0];
                    div_quo_next = {div_quo_reg[54:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_sh;
                    div_quo_next = {div_quo_reg[54:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_T_DIVF;
            end
            ST_T_DIVF:
            begin
                // truncated quotient with sign, saturated to the accumulator range
                if (tneg_reg)
                    tb_next[comp_reg] = (div_quo_reg > 56'h8000_0000_0000) ? ACC_MIN
                                        : -$signed(div_quo_reg[47:0]);
                else
                    tb_next[comp_reg] = (div_quo_reg > 56'h7FFF_FFFF_FFFF) ? ACC_MAX
                                        : $signed(div_quo_reg[47:0]);
                if (comp_reg == 3'd5)
                begin
                    comp_next  = '0;
                    state_next = ST_T_ARD;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_T_NUM0;
                end
            end
            // read-modify-write of each corner's accumulators
            ST_T_ARD: state_next = ST_T_AWR;
            ST_T_AWR:
            begin
                awe          = 1'b1;
                awdata.tan_x = sat_add48(ard_reg.tan_x, tb_reg[0]);
                awdata.tan_y = sat_add48(ard_reg.tan_y, tb_reg[1]);
                awdata.tan_z = sat_add48(ard_reg.tan_z, tb_reg[2]);
                awdata.bit_x = sat_add48(ard_reg.bit_x, tb_reg[3]);
                awdata.bit_y = sat_add48(ard_reg.bit_y, tb_reg[4]);
                awdata.bit_z = sat_add48(ard_reg.bit_z, tb_reg[5]);
                if (comp_reg == 3'd2)
                    state_next = ST_IDLE;
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_T_ARD;
                end
            end

            // resolve
            ST_R_RD: state_next = ST_R_CAP;
            ST_R_CAP:
            begin
                n_next[0]  = vrd_reg.norm_x;
                n_next[1]  = vrd_reg.norm_y;
                n_next[2]  = vrd_reg.norm_z;
                bt_next[0] = ard_reg.bit_x;
                bt_next[1] = ard_reg.bit_y;
                bt_next[2] = ard_reg.bit_z;
                vm_next[0] = mag48(ard_reg.tan_x);
                vm_next[1] = mag48(ard_reg.tan_y);
                vm_next[2] = mag48(ard_reg.tan_z);
                vs_next[0] = ard_reg.tan_x[47];
                vs_next[1] = ard_reg.tan_y[47];
                vs_next[2] = ard_reg.tan_z[47];
                phase_next = PH_T;
                state_next = ST_ALIGN;
            end
            // shift magnitudes one bit a cycle until the largest lies in [2^29, 2^30)
            ST_ALIGN:
            begin
                if (vmax == '0)
                begin
                    case (phase_reg)
                        PH_T, PH_O:
                        begin
                            // fall back to the normal crossed with the x or y axis
                            if (20'(nmag[0]) * 20'd10 < 20'd147456)
                            begin
                                vm_next[0] = '0;
                                vm_next[1] = 48'(nmag[2]);
                                vm_next[2] = 48'(nmag[1]);
                                vs_next[0] = 1'b0;
                                vs_next[1] = n_reg[2][15];
                                vs_next[2] = (n_reg[1] > 16'sd0);
                            end
                            else
                            begin
                                vm_next[0] = 48'(nmag[2]);
                                vm_next[1] = '0;
                                vm_next[2] = 48'(nmag[0]);
                                vs_next[0] = (n_reg[2] > 16'sd0);
                                vs_next[1] = 1'b0;
                                vs_next[2] = n_reg[0][15];
                            end
                            phase_next = PH_F;
                        end
                        PH_F:
                        begin
                            // degenerate normal: tangent is +x
                            res_next[0] = ONE_Q14;
                            res_next[1] = '0;
                            res_next[2] = '0;
                            for (int i = 0; i < 3; i++)
                            begin
                                vm_next[i] = mag48(bt_reg[i]);
                                vs_next[i] = bt_reg[i][47];
                            end
                            phase_next = PH_B;
                        end
                        default:
                        begin
                            // zero bitangent reports positive handedness
                            hd_next    = 1'b0;
                            state_next = ST_R_OUT;
                        end
                    endcase
                end
                else if (vmax[47:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] >> 1;
                end
                else if (!vmax[29])
                begin
                    for (int i = 0; i < 3; i++)
                        vm_next[i] = vm_reg[i] << 1;
                end
                else
                begin
                    comp_next = '0;
                    case (phase_reg)
                        PH_T:       state_next = ST_R_NDT;
                        PH_O, PH_F: state_next = ST_R_LEN;
                        default:    state_next = ST_R_CRA;
                    endcase
                end
            end
            // n dot t
            ST_R_NDT:
            begin
                mul_a   = 34'(n_reg[comp_reg[1:0]]);
                mul_b   = tsv[comp_reg[1:0]];
                macc_op = (comp_reg == 3'd0) ? MAC_LOAD : MAC_ADD;
                if (comp_reg == 3'd2)
                    state_next = ST_R_NDTS;
                else
                    comp_next = comp_reg + 1'b1;
            end
            ST_R_NDTS:
            begin
                ndt_next   = macc_reg[47:0];
                comp_next  = '0;
                state_next = ST_R_PLO;
            end
            // n * ndt in two partial products
            ST_R_PLO:
            begin
                mul_a      = 34'(n_reg[comp_reg[1:0]]);
                mul_b      = $signed({10'd0, ndt_reg[23:0]});
                macc_op    = MAC_LOAD;
                state_next = ST_R_PHI;
            end
            ST_R_PHI:
            begin
                mul_a      = 34'(n_reg[comp_reg[1:0]]);
                mul_b      = 34'($signed(ndt_reg[47:24]));
                macc_op    = MAC_ADDSH;
                state_next = ST_R_OSUB;
            end
            ST_R_OSUB:
            begin
                ow_next[comp_reg[1:0]] = 36'(tsv[comp_reg[1:0]]) - rnd_s;
                if (comp_reg == 3'd2)
                    state_next = ST_R_OLD;
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_R_PLO;
                end
            end
            ST_R_OLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vm_next[i] = ow_reg[i][35] ? 48'(-ow_reg[i]) : 48'(ow_reg[i]);
                    vs_next[i] = ow_reg[i][35];
                end
                phase_next = PH_O;
                state_next = ST_ALIGN;
            end
            // squared length
            ST_R_LEN:
            begin
                mul_a   = $signed({4'd0, vm_reg[comp_reg[1:0]][29:0]});
                mul_b   = $signed({4'd0, vm_reg[comp_reg[1:0]][29:0]});
                macc_op = (comp_reg == 3'd0) ? MAC_LOAD : MAC_ADD;
                if (comp_reg == 3'd2)
                    state_next = ST_R_SQI;
                else
                    comp_next = comp_reg + 1'b1;
            end
            ST_R_SQI:
            begin
                sx_next    = macc_reg[63:0];
                sr_next    = '0;
                sbit_next  = 64'h4000_0000_0000_0000;
                cnt_next   = '0;
                state_next = ST_R_SQRT;
            end
            ST_R_SQRT:
            begin
                if (sx_reg >= sq_trial)
                begin
                    sx_next = sx_reg - sq_trial;
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end
                else
                    sr_next = sr_reg >> 1;
                sbit_next = sbit_reg >> 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_R_SQF;
            end
            ST_R_SQF:
            begin
                len_next   = sr_reg[31:0];
                comp_next  = '0;
                state_next = ST_R_NDS;
            end
            // component = round(|o| * 16384 / len)
            ST_R_NDS:
            begin
                div_quo_next = 56'({vm_reg[comp_reg[1:0]][29:0], 14'd0}) +
                               56'(len_reg >> 1);
                div_rem_next = '0;
                div_den_next = 35'(len_reg);
                cnt_next     = '0;
                state_next   = ST_R_NDIV;
            end
            ST_R_NDIV:
            begin
                if (!div_diff[36])
                begin
                    div_rem_next = div_diff[35:0];
                    div_quo_next = {div_quo_reg[54:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_sh;
                    div_quo_next = {div_quo_reg[54:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_R_NDF;
            end
            ST_R_NDF:
            begin
                res_next[comp_reg[1:0]] = vs_reg[comp_reg[1:0]] ? -$signed(qclamp)
                                                                 : $signed(qclamp);
                if (comp_reg == 3'd2)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vm_next[i] = mag48(bt_reg[i]);
                        vs_next[i] = bt_reg[i][47];
                    end
                    phase_next = PH_B;
                    state_next = ST_ALIGN;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_R_NDS;
                end
            end
            // cross(n, tangent), one component per pass
            ST_R_CRA:
            begin
                mul_a      = 34'(n_reg[cj]);
                mul_b      = 34'(res_reg[ck]);
                macc_op    = MAC_LOAD;
                state_next = ST_R_CRB;
            end
            ST_R_CRB:
            begin
                mul_a      = 34'(n_reg[ck]);
                mul_b      = 34'(res_reg[cj]);
                macc_op    = MAC_SUB;
                state_next = ST_R_CRS;
            end
            ST_R_CRS:
            begin
                cr_next[comp_reg[1:0]] = macc_reg[32:0];
                if (comp_reg == 3'd2)
                begin
                    comp_next  = '0;
                    state_next = ST_R_DOT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_R_CRA;
                end
            end
            // dot with the aligned bitangent, only the sign is kept
            ST_R_DOT:
            begin
                mul_a   = 34'(cr_reg[comp_reg[1:0]]);
                mul_b   = tsv[comp_reg[1:0]];
                macc_op = (comp_reg == 3'd0) ? MAC_LOAD : MAC_ADD;
                if (comp_reg == 3'd2)
                    state_next = ST_R_HD;
                else
                    comp_next = comp_reg + 1'b1;
            end
            ST_R_HD:
            begin
                hd_next    = macc_reg[69];
                state_next = ST_R_OUT;
            end
            ST_R_OUT:
            begin
                if (!o_valid_reg || m_tready)
                begin
                    o_valid_next = 1'b1;
                    o_idx_next   = ia_reg;
                    o_tan_next   = res_reg;
                    o_hd_next    = hd_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory addressing
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  vaddr = IDX_W'(in_ia);
            ST_T_RDB: vaddr = IDX_W'(ib_reg);
            ST_T_RDC: vaddr = IDX_W'(ic_reg);
            default:  vaddr = IDX_W'(ia_reg);
        endcase
        case (state_reg)
            ST_CLR:             aaddr = clr_reg;
            ST_T_ARD, ST_T_AWR:
                case (comp_reg)
                    3'd0:    aaddr = IDX_W'(ia_reg);
                    3'd1:    aaddr = IDX_W'(ib_reg);
                    default: aaddr = IDX_W'(ic_reg);
                endcase
            default:            aaddr = IDX_W'(ia_reg);
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'd0, o_tan_reg[2], o_tan_reg[1], o_tan_reg[0], o_idx_reg};
    assign m_tuser  = o_hd_reg;

    // control state, reset starts the accumulator clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            comp_reg    <= '0;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            phase_reg   <= PH_T;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            comp_reg    <= comp_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            phase_reg   <= phase_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        ic_reg      <= ic_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        du1_reg     <= du1_next;
        dv1_reg     <= dv1_next;
        du2_reg     <= du2_next;
        dv2_reg     <= dv2_next;
        det_reg     <= det_next;
        tneg_reg    <= tneg_next;
        tb_reg      <= tb_next;
        macc_reg    <= macc_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        n_reg       <= n_next;
        vm_reg      <= vm_next;
        vs_reg      <= vs_next;
        bt_reg      <= bt_next;
        ndt_reg     <= ndt_next;
        ow_reg      <= ow_next;
        len_reg     <= len_next;
        sx_reg      <= sx_next;
        sr_reg      <= sr_next;
        sbit_reg    <= sbit_next;
        res_reg     <= res_next;
        cr_reg      <= cr_next;
        hd_reg      <= hd_next;
        o_idx_reg   <= o_idx_next;
        o_tan_reg   <= o_tan_next;
        o_hd_reg    <= o_hd_next;
    end

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the vertex tangent frame builder unit
`timescale 1ns / 1ps

module tb_top;
    import vtfb_pkg::*;

    localparam int       LIMIT_CYCLES = 4000000;
    // slowest item is a clear pass over all 1024 accumulator entries
    localparam int       DRAIN_CYCLES = 1200;
    localparam logic [2:0] REG_VCOUNT = 3'd0;
    localparam logic [2:0] REG_THRESH = 3'd4;

    typedef longint vec3_t[3];

    typedef struct packed {
        logic [1:0]         act;
        logic [9:0]         ia;
        logic [9:0]         ib;
        logic [9:0]         ic;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [15:0] tu;
        logic signed [15:0] tv;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } op_t;

    typedef struct packed {
        logic [9:0]         vi;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               hn;
    } frame_t;

    typedef struct {
        op_t    op;
        bit     typed;
        frame_t fr;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    // index_a, index_b, index_c, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
    logic [183:0] s_tdata;
    // action
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // vertex_index, tan_x, tan_y, tan_z
    logic [63:0]  m_tdata;
    // handedness_negative
    logic         m_tuser;

    vertex_tangent_frame_builder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // mirror of the block: vertex store, accumulators and registers
    longint vx_pos[1024][3];
    longint vx_uv[1024][2];
    longint vx_nrm[1024][3];
    longint acc_tan[1024][3];
    longint acc_bit[1024][3];
    bit     loaded[1024];
    int     loaded_list[$];
    int     vcount;
    int     thresh;

    frame_t frames_due[$];

    int     errors;
    int     n_xfers;
    int     n_frames;
    int     n_tris;
    int     n_clears;
    int     snd_idle;
    int     rcv_stall;
    int     cycles;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- fixed point helpers

    function automatic longint unsigned magn(longint x);
        if (x < 0)
            return 64'(-x);
        return 64'(x);
    endfunction

    function automatic longint sat48(longint x);
        if (x > 64'sh7FFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF;
        if (x < -64'sh8000_0000_0000)
            return -64'sh8000_0000_0000;
        return x;
    endfunction

    // scale so the largest magnitude sits in [2^29, 2^30), zero vector reports false
    function automatic bit scale_vec(inout vec3_t v);
        longint unsigned m;
        longint unsigned a;
        int rs;
        int ls;
        m  = 0;
        rs = 0;
        ls = 0;
        for (int i = 0; i < 3; i++)
            if (magn(v[i]) > m)
                m = magn(v[i]);
        if (m == 0)
            return 1'b0;
        while ((m >> rs) >= (64'd1 << 30))
            rs++;
        while ((m << ls) < (64'd1 << 29))
            ls++;
        for (int i = 0; i < 3; i++)
        begin
            a = (magn(v[i]) >> rs) << ls;
            if (v[i] < 0)
                v[i] = -longint'(a);
            else
                v[i] = longint'(a);
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(inout vec3_t v, output vec3_t u);
        longint unsigned len2;
        longint unsigned len;
        longint unsigned q;
        if (!scale_vec(v))
            return 1'b0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
            len2 += magn(v[i]) * magn(v[i]);
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            q = (magn(v[i]) * 16384 + (len >> 1)) / len;
            if (q > 16384)
                q = 16384;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- frame predictor

    task automatic accumulate_triangle(input int a, input int b, input int c);
        longint e1[3];
        longint e2[3];
        longint tv[3];
        longint bv[3];
        longint du1;
        longint dv1;
        longint du2;
        longint dv2;
        longint det;
        if (a >= vcount || b >= vcount || c >= vcount)
            return;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = vx_pos[b][i] - vx_pos[a][i];
            e2[i] = vx_pos[c][i] - vx_pos[a][i];
        end
        du1 = vx_uv[b][0] - vx_uv[a][0];
        dv1 = vx_uv[b][1] - vx_uv[a][1];
        du2 = vx_uv[c][0] - vx_uv[a][0];
        dv2 = vx_uv[c][1] - vx_uv[a][1];
        det = du1 * dv2 - du2 * dv1;
        // near-singular uv mapping, triangle dropped
        if (magn(det) <= longint'(thresh))
            return;
        n_tris++;
        for (int i = 0; i < 3; i++)
        begin
            tv[i] = sat48(((e1[i] * dv2 - e2[i] * dv1) * 4096) / det);
            bv[i] = sat48(((e2[i] * du1 - e1[i] * du2) * 4096) / det);
        end
        foreach (tv[i])
        begin
            acc_tan[a][i] = sat48(acc_tan[a][i] + tv[i]);
            acc_tan[b][i] = sat48(acc_tan[b][i] + tv[i]);
            acc_tan[c][i] = sat48(acc_tan[c][i] + tv[i]);
            acc_bit[a][i] = sat48(acc_bit[a][i] + bv[i]);
            acc_bit[b][i] = sat48(acc_bit[b][i] + bv[i]);
            acc_bit[c][i] = sat48(acc_bit[c][i] + bv[i]);
        end
    endtask

    function automatic frame_t resolve_frame(input int v);
        vec3_t  n;
        vec3_t  t;
        vec3_t  o;
        vec3_t  r;
        vec3_t  bt;
        longint cr[3];
        longint ndt;
        longint p;
        longint unsigned rq;
        longint hd;
        bit     ok;
        frame_t f;
        ok = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            n[i]  = vx_nrm[v][i];
            t[i]  = acc_tan[v][i];
            bt[i] = acc_bit[v][i];
        end
        // gram-schmidt against the normal
        if (scale_vec(t))
        begin
            ndt = n[0] * t[0] + n[1] * t[1] + n[2] * t[2];
            for (int i = 0; i < 3; i++)
            begin
                p  = n[i] * ndt;
                rq = (magn(p) + (64'd1 << 27)) >> 28;
                o[i] = t[i] - ((p < 0) ? -longint'(rq) : longint'(rq));
            end
            ok = unit_vec(o, r);
        end
        // degenerate tangent: cross with x axis unless the normal is close to x
        if (!ok)
        begin
            if (magn(n[0]) * 10 < 9 * 16384)
            begin
                o[0] = 0;
                o[1] = n[2];
                o[2] = -n[1];
            end
            else
            begin
                o[0] = -n[2];
                o[1] = 0;
                o[2] = n[0];
            end
            if (!unit_vec(o, r))
            begin
                r[0] = 16384;
                r[1] = 0;
                r[2] = 0;
            end
        end
        cr[0] = n[1] * r[2] - n[2] * r[1];
        cr[1] = n[2] * r[0] - n[0] * r[2];
        cr[2] = n[0] * r[1] - n[1] * r[0];
        hd = 0;
        if (scale_vec(bt))
            hd = cr[0] * bt[0] + cr[1] * bt[1] + cr[2] * bt[2];
        f.vi = v[9:0];
        f.tx = r[0][15:0];
        f.ty = r[1][15:0];
        f.tz = r[2][15:0];
        f.hn = (hd < 0);
        return f;
    endfunction

    // advance the mirror by one accepted transfer and queue any frame it yields
    task automatic apply_op(input op_t op, input bit typed, input frame_t tf);
        case (op.act)
            ACT_LOAD:
            begin
                vx_pos[op.ia][0] = op.px;
                vx_pos[op.ia][1] = op.py;
                vx_pos[op.ia][2] = op.pz;
                vx_uv[op.ia][0]  = op.tu;
                vx_uv[op.ia][1]  = op.tv;
                vx_nrm[op.ia][0] = op.nx;
                vx_nrm[op.ia][1] = op.ny;
                vx_nrm[op.ia][2] = op.nz;
                if (!loaded[op.ia])
                begin
                    loaded[op.ia] = 1'b1;
                    loaded_list.push_back(op.ia);
                end
            end
            ACT_TRI:
                accumulate_triangle(op.ia, op.ib, op.ic);
            ACT_RESOLVE:
                if (op.ia < vcount)
                begin
                    if (typed)
                        frames_due.push_back(tf);
                    else
                        frames_due.push_back(resolve_frame(op.ia));
                end
            default:
            begin
                n_clears++;
                foreach (acc_tan[v, i])
                begin
                    acc_tan[v][i] = 0;
                    acc_bit[v][i] = 0;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus builders

    function automatic op_t load_op(input int idx, input int px, input int py, input int pz,
                                    input int u, input int v, input int nx, input int ny,
                                    input int nz);
        op_t op;
        op    = '0;
        op.act = ACT_LOAD;
        op.ia = idx;
        op.px = px;
        op.py = py;
        op.pz = pz;
        op.tu = u;
        op.tv = v;
        op.nx = nx;
        op.ny = ny;
        op.nz = nz;
        return op;
    endfunction

    function automatic op_t cmd_op(input logic [1:0] act, input int a, input int b,
                                   input int c);
        op_t op;
        op     = '0;
        op.act = act;
        op.ia  = a;
        op.ib  = b;
        op.ic  = c;
        return op;
    endfunction

    function automatic frame_t frame_of(input int v, input int x, input int y, input int z);
        frame_t f;
        f.vi = v;
        f.tx = x;
        f.ty = y;
        f.tz = z;
        f.hn = 1'b0;
        return f;
    endfunction

    // signed value of random width, so small and full-range values both show up
    function automatic int rand_signed(input int wmin, input int wmax);
        int w;
        w = $urandom_range(wmax, wmin);
        return (int'($urandom) <<< (32 - w)) >>> (32 - w);
    endfunction

    function automatic int live_index();
        int k;
        if (vcount == 0 || loaded_list.size() == 0)
            return -1;
        repeat (24)
        begin
            k = loaded_list[$urandom_range(loaded_list.size() - 1)];
            if (k < vcount)
                return k;
        end
        return -1;
    endfunction

    function automatic int dead_index();
        if (vcount >= 1024)
            return -1;
        return $urandom_range(1023, vcount);
    endfunction

    function automatic op_t random_op();
        int  r;
        int  a;
        int  b;
        int  c;
        int  ax;
        op_t op;
        r = $urandom_range(99);
        a = live_index();
        b = live_index();
        c = live_index();
        if (r >= 94 && dead_index() >= 0)
            // noise: triangle with a corner past the loaded range
            return cmd_op(ACT_TRI, a < 0 ? dead_index() : a, dead_index(), $urandom_range(1023));
        if (r >= 92)
            return cmd_op(ACT_CLEAR, $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1023));
        if (r >= 65 && a >= 0)
        begin
            if ($urandom_range(99) < 8 && dead_index() >= 0)
                a = dead_index();
            return cmd_op(ACT_RESOLVE, a, $urandom_range(1023), $urandom_range(1023));
        end
        if (r >= 25 && a >= 0 && b >= 0 && c >= 0)
        begin
            if ($urandom_range(99) < 10 && dead_index() >= 0)
                c = dead_index();
            else if ($urandom_range(99) < 5)
                b = a;
            return cmd_op(ACT_TRI, a, b, c);
        end
        // vertex load, mostly inside the live range
        if (vcount > 0 && $urandom_range(99) < 90)
            a = $urandom_range(vcount - 1);
        else
            a = $urandom_range(1023);
        op = load_op(a, rand_signed(4, 24), rand_signed(4, 24), rand_signed(4, 24),
                     rand_signed(2, 16), rand_signed(2, 16), 0, 0, 0);
        if ($urandom_range(99) < 15)
        begin
            ax = $urandom_range(2);
            op.nx = (ax == 0) ? ($urandom_range(1) ? 16384 : -16384) : 0;
            op.ny = (ax == 1) ? ($urandom_range(1) ? 16384 : -16384) : 0;
            op.nz = (ax == 2) ? ($urandom_range(1) ? 16384 : -16384) : 0;
        end
        else
        begin
            op.nx = int'($urandom_range(32768)) - 16384;
            op.ny = int'($urandom_range(32768)) - 16384;
            op.nz = int'($urandom_range(32768)) - 16384;
        end
        return op;
    endfunction

    // ---------------------------------------------------------------- bus drivers

    task automatic send_op(input op_t op, input bit typed, input frame_t tf);
        if ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, op.nz, op.ny, op.nx, op.tv, op.tu, op.pz, op.py, op.px,
                     op.ic, op.ib, op.ia};
        s_tuser  <= op.act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_xfers++;
        apply_op(op, typed, tf);
    endtask

    // register write, only once every frame is back and the sequencer has settled
    task automatic write_reg(input logic [2:0] addr, input int value);
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // read back in the next transfer
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata != 32'(value))
        begin
            if (errors < 10)
                $display("register %0d readback: expected %0d, got %0d", addr, value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == REG_VCOUNT)
            vcount = value;
        else
            thresh = value;
    endtask

    task automatic run_phase(input int vc, input int thr, input int sidle, input int rstall,
                             input int items, input int pause_at);
        write_reg(REG_VCOUNT, vc);
        write_reg(REG_THRESH, thr);
        snd_idle  = sidle;
        rcv_stall = rstall;
        for (int i = 0; i < items; i++)
        begin
            if (i == pause_at)
            begin
                // hold the sender until every pending frame has drained
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (frames_due.size() != 0)
                    @(posedge clk);
            end
            send_op(random_op(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result checker

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_stall);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frames_due.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected frame: vertex %0d", m_tdata[9:0]);
                errors++;
            end
            else
            begin
                frame_t f;
                f = frames_due.pop_front();
                n_frames++;
                if (m_tdata[9:0] !== f.vi || m_tdata[25:10] !== f.tx
                    || m_tdata[41:26] !== f.ty || m_tdata[57:42] !== f.tz
                    || m_tuser !== f.hn)
                begin
                    if (errors < 10)
                        $display("frame mismatch: expected v%0d t(%0d %0d %0d) h%0d, got v%0d t(%0d %0d %0d) h%0d",
                                 f.vi, f.tx, f.ty, f.tz, f.hn, m_tdata[9:0],
                                 $signed(m_tdata[25:10]), $signed(m_tdata[41:26]),
                                 $signed(m_tdata[57:42]), m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL vertex_tangent_frame_builder_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        row_t rows[$];
        clk       = 1'b0;
        cycles    = 0;
        errors    = 0;
        n_xfers   = 0;
        n_frames  = 0;
        n_tris    = 0;
        n_clears  = 0;
        snd_idle  = 0;
        rcv_stall = 0;
        vcount    = 0;
        thresh    = 0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_LOAD;
        m_tready <= 1'b0;
        foreach (acc_tan[v, i])
        begin
            acc_tan[v][i] = 0;
            acc_bit[v][i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: axis normals, extreme positions and uvs, every action
        rows.push_back('{load_op(0, 0, 0, 0, 0, 0, 0, 0, 16384), 1'b0, '0});
        rows.push_back('{load_op(1, 4096, 0, 0, 4096, 0, 16384, 0, 0), 1'b0, '0});
        rows.push_back('{load_op(2, 0, 4096, 0, 0, 4096, 0, 0, 16384), 1'b0, '0});
        rows.push_back('{load_op(3, 8388607, -8388608, 8388607, 32767, -32768, 16384, 0, 0),
                         1'b0, '0});
        rows.push_back('{load_op(4, -8388608, 8388607, -8388608, -32768, 32767, 0, 0, 0),
                         1'b0, '0});
        rows.push_back('{load_op(5, 1, -1, 0, -32768, -32768, 0, -16384, 0), 1'b0, '0});
        rows.push_back('{load_op(6, 8388607, 8388607, 8388607, 1, 1, -16384, 0, 0), 1'b0, '0});
        rows.push_back('{load_op(7, -8388608, -8388608, -8388608, 1, 0, 0, 16384, 0),
                         1'b0, '0});
        // empty accumulators fall back to the axis cross products, zero normal gives +x
        rows.push_back('{cmd_op(ACT_RESOLVE, 0, 0, 0), 1'b1, frame_of(0, 0, 16384, 0)});
        rows.push_back('{cmd_op(ACT_RESOLVE, 4, 0, 0), 1'b1, frame_of(4, 16384, 0, 0)});
        rows.push_back('{cmd_op(ACT_RESOLVE, 3, 0, 0), 1'b1, frame_of(3, 0, 0, 16384)});
        rows.push_back('{cmd_op(ACT_RESOLVE, 6, 0, 0), 1'b1, frame_of(6, 0, 0, -16384)});
        rows.push_back('{cmd_op(ACT_RESOLVE, 8, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_TRI, 0, 1, 2), 1'b0, '0});
        // tangent along the normal of vertex 1 collapses under orthogonalization
        rows.push_back('{cmd_op(ACT_RESOLVE, 1, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_RESOLVE, 2, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_TRI, 0, 0, 1), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_TRI, 0, 1, 9), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_TRI, 3, 4, 5), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_TRI, 3, 4, 5), 1'b0, '0});
        // unit determinant with extreme position edges
        rows.push_back('{cmd_op(ACT_TRI, 0, 6, 7), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_RESOLVE, 3, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_RESOLVE, 5, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_RESOLVE, 7, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_CLEAR, 0, 0, 0), 1'b0, '0});
        rows.push_back('{cmd_op(ACT_RESOLVE, 0, 0, 0), 1'b1, frame_of(0, 0, 16384, 0)});

        write_reg(REG_VCOUNT, 8);
        write_reg(REG_THRESH, 0);
        foreach (rows[i])
            send_op(rows[i].op, rows[i].typed, rows[i].fr);
        s_tvalid <= 1'b0;

        // random phases across register settings and idle patterns
        run_phase(16,   0,     0,  0,  260, -1);
        run_phase(1024, 65535, 46, 0,  260, -1);
        run_phase(64,   300,   0,  46, 260, 120);
        run_phase(0,    0,     18, 18, 30,  -1);
        run_phase(200,  12345, 18, 18, 280, -1);

        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers: %0d triangles accumulated, %0d clears, %0d frames checked",
                 n_xfers, n_tris, n_clears, n_frames);
        $display("mismatches: %0d, frames still pending: %0d", errors, frames_due.size());
        if (errors == 0 && frames_due.size() == 0)
            $display("PASS vertex_tangent_frame_builder_unit");
        else
            $display("FAIL vertex_tangent_frame_builder_unit");
        $finish;
    end

endmodule
